// ----- rtl/core/three_pool_page_free_list_allocator_unit_assert.svh -----
// Assertion macros for the three-pool page free list allocator.
// Used by the port-level checker; no other dependencies.
`ifndef THREE_POOL_PAGE_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define THREE_POOL_PAGE_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define TPFLA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TPFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define TPFLA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tpfla_pkg.sv -----
// Shared types, codes and geometry helpers for the three-pool page allocator.
// No dependencies; imported by the front, back, top-level and checker modules.
package tpfla_pkg;

    localparam int DEF_MAX_AREA_PAGES = 4096;
    localparam int DEF_PAGE_BYTES     = 4096;

    localparam int ADDR_W     = 64;
    localparam int OPC_W      = 2;
    localparam int POOL_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int FREE_W     = 13;
    localparam int ORDER_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    // Widest pool size or offset over the whole parameter range (65536 pages)
    localparam int GEO_W      = 17;
    // Widest page index over the whole parameter range
    localparam int IDX_MAX_W  = 16;
    localparam int CMDQ_DEPTH = 2;

    localparam int S_FIELDS_W = OPC_W + POOL_W + ADDR_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_PAD_W    = S_TDATA_W - S_FIELDS_W;
    localparam int M_FIELDS_W = STATUS_W + ADDR_W + FREE_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam logic [ADDR_W-1:0]  RST_AREA_BASE  = '0;
    localparam logic [ORDER_W-1:0] RST_AREA_ORDER = 4'd12;
    localparam logic [ORDER_W-1:0] RST_TOP_ORDER  = 4'd0;
    localparam logic [ORDER_W-1:0] RST_MID_ORDER  = 4'd2;

    localparam logic [POOL_W-1:0] POOL_TOP  = 2'd0;
    localparam logic [POOL_W-1:0] POOL_MID  = 2'd1;
    localparam logic [POOL_W-1:0] POOL_LEAF = 2'd2;

    typedef enum logic [OPC_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_CHECK = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_EMPTY        = 2'd1,
        ST_MISALIGNED   = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AREA_BASE  = 2'd0,
        REG_AREA_ORDER = 2'd1,
        REG_TOP_ORDER  = 2'd2,
        REG_MID_ORDER  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_INIT,
        CMD_ALLOC,
        CMD_FREE,
        CMD_REPORT
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ALLOC_RD,
        BK_INIT_SWEEP,
        BK_INIT_DONE
    } back_state_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [POOL_W-1:0]      pool;
        logic [IDX_MAX_W-1:0]   idx;
        status_t                status;
    } cmd_t;

    typedef struct packed {
        logic [GEO_W-1:0] top_size;
        logic [GEO_W-1:0] mid_size;
        logic [GEO_W-1:0] leaf_size;
        logic [GEO_W-1:0] mid_off;
        logic [GEO_W-1:0] leaf_off;
        logic [GEO_W-1:0] max_size;
    } geo_t;

    function automatic logic [GEO_W-1:0] pow2_capped(
        input logic [ORDER_W-1:0] order,
        input logic [GEO_W-1:0]   cap
    );
        logic [GEO_W:0] v;
        v = (GEO_W + 1)'(1) << order;
        return (v > {1'b0, cap}) ? cap : v[GEO_W-1:0];
    endfunction

    function automatic geo_t pool_geometry(
        input logic [ORDER_W-1:0] area_order,
        input logic [ORDER_W-1:0] top_order,
        input logic [ORDER_W-1:0] mid_order,
        input logic [GEO_W-1:0]   max_pages
    );
        geo_t             g;
        logic [GEO_W-1:0] total;
        logic [GEO_W-1:0] big;
        total       = pow2_capped(area_order, max_pages);
        g.top_size  = pow2_capped(top_order, total);
        g.mid_size  = pow2_capped(mid_order, total - g.top_size);
        g.leaf_size = total - g.top_size - g.mid_size;
        g.mid_off   = g.top_size;
        g.leaf_off  = g.top_size + g.mid_size;
        big         = (g.top_size > g.mid_size) ? g.top_size : g.mid_size;
        g.max_size  = (big > g.leaf_size) ? big : g.leaf_size;
        return g;
    endfunction

endpackage

// ----- rtl/core/tpfla_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the free list link memories.
module tpfla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        // hold read data while no read is issued
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/tpfla_front.sv -----
// Front end: accepts input items, computes the pool-relative page number,
// classifies the item into a back-end command. Depends on tpfla_pkg.
module tpfla_front #(
    parameter int PAGE_BYTES = tpfla_pkg::DEF_PAGE_BYTES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tpfla_pkg::OPC_W-1:0]  in_opcode,
    input  logic [tpfla_pkg::POOL_W-1:0] in_pool,
    input  logic [tpfla_pkg::ADDR_W-1:0] in_page_address,
    input  logic [tpfla_pkg::ADDR_W-1:0] area_base,
    input  tpfla_pkg::geo_t             geo,
    output logic                        push_valid,
    input  logic                        push_ready,
    output tpfla_pkg::cmd_t             push_cmd
);
    import tpfla_pkg::*;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    logic                a_valid_reg;
    logic [OPC_W-1:0]    a_opcode_reg;
    logic [POOL_W-1:0]   a_pool_reg;
    logic                a_misaligned_reg;
    logic [ADDR_W-1:0]   a_diff_reg;

    logic [ADDR_W-1:0]   page_num;
    logic [ADDR_W-1:0]   rel_page;
    logic [POOL_W-1:0]   sel_pool;
    logic [GEO_W-1:0]    sel_off;
    logic [GEO_W-1:0]    sel_size;
    logic                out_of_range;

    assign in_ready = !a_valid_reg || push_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (in_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    // Address minus base is taken here so the classify stage has one wide subtract.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            a_opcode_reg     <= in_opcode;
            a_pool_reg       <= in_pool;
            a_misaligned_reg <= |in_page_address[PAGE_SHIFT-1:0];
            a_diff_reg       <= in_page_address - area_base;
        end
    end

    assign page_num = a_diff_reg >> PAGE_SHIFT;
    assign sel_pool = (a_opcode_reg == OP_CHECK) ? POOL_LEAF : a_pool_reg;

    always_comb begin
        case (sel_pool)
            POOL_TOP: begin
                sel_off  = '0;
                sel_size = geo.top_size;
            end
            POOL_MID: begin
                sel_off  = geo.mid_off;
                sel_size = geo.mid_size;
            end
            POOL_LEAF: begin
                sel_off  = geo.leaf_off;
                sel_size = geo.leaf_size;
            end
            default: begin
                // no such pool: an empty range rejects every page
                sel_off  = '0;
                sel_size = '0;
            end
        endcase
    end

    assign rel_page     = page_num - ADDR_W'(sel_off);
    assign out_of_range = rel_page >= ADDR_W'(sel_size);

    always_comb begin
        push_cmd.kind   = CMD_REPORT;
        push_cmd.pool   = a_pool_reg;
        push_cmd.idx    = rel_page[IDX_MAX_W-1:0];
        push_cmd.status = ST_OK;
        case (a_opcode_reg)
            OP_INIT: begin
                push_cmd.kind = CMD_INIT;
            end
            OP_ALLOC: begin
                if (a_pool_reg > POOL_LEAF) begin
                    push_cmd.status = ST_OUT_OF_RANGE;
                end else begin
                    push_cmd.kind = CMD_ALLOC;
                end
            end
            OP_FREE: begin
                if (a_misaligned_reg) begin
                    push_cmd.status = ST_MISALIGNED;
                end else if (out_of_range) begin
                    push_cmd.status = ST_OUT_OF_RANGE;
                end else begin
                    push_cmd.kind = CMD_FREE;
                end
            end
            OP_CHECK: begin
                push_cmd.status = out_of_range ? ST_OUT_OF_RANGE : ST_OK;
            end
            default: begin
                push_cmd.kind = CMD_REPORT;
            end
        endcase
    end

    assign push_valid = a_valid_reg;

endmodule

// ----- rtl/core/tpfla_queue.sv -----
// Short command queue between the front and back ends.
// Flip-flop storage; no dependencies.
module tpfla_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/tpfla_back.sv -----
// Back end: owns the pool heads, the link memories and the free counter,
// executes commands and drives the result register. Depends on tpfla_pkg, tpfla_ram.
module tpfla_back #(
    parameter int MAX_AREA_PAGES = tpfla_pkg::DEF_MAX_AREA_PAGES,
    parameter int PAGE_BYTES     = tpfla_pkg::DEF_PAGE_BYTES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  tpfla_pkg::cmd_t                cmd,
    input  logic [tpfla_pkg::ADDR_W-1:0]   area_base,
    input  tpfla_pkg::geo_t                geo,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tpfla_pkg::STATUS_W-1:0] out_status,
    output logic [tpfla_pkg::ADDR_W-1:0]   out_granted,
    output logic [tpfla_pkg::FREE_W-1:0]   out_free_pages
);
    import tpfla_pkg::*;

    localparam int IDX_W      = $clog2(MAX_AREA_PAGES);
    localparam int HEAD_W     = $clog2(MAX_AREA_PAGES + 1);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [HEAD_W-1:0] EMPTY_MARK = HEAD_W'(MAX_AREA_PAGES);

    back_state_t       state_reg, state_next;
    logic [HEAD_W-1:0] top_head_reg, top_head_next;
    logic [HEAD_W-1:0] mid_head_reg, mid_head_next;
    logic [HEAD_W-1:0] leaf_head_reg, leaf_head_next;
    logic [HEAD_W-1:0] free_cnt_reg, free_cnt_next;
    logic [IDX_W-1:0]  sweep_reg, sweep_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [ADDR_W-1:0] out_granted_reg, out_granted_next;
    logic [FREE_W-1:0] out_free_reg, out_free_next;

    logic [2:0]        ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [HEAD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [HEAD_W-1:0] top_link, mid_link, leaf_link;

    logic [HEAD_W-1:0] sel_head;
    logic [HEAD_W-1:0] sel_link;
    logic [GEO_W-1:0]  sel_off;
    logic [IDX_W-1:0]  cmd_idx;
    logic              out_free;
    logic [HEAD_W-1:0] cnt_inc;
    logic [HEAD_W-1:0] cnt_dec;
    logic [GEO_W-1:0]  geo_total;
    logic              sweep_last;
    logic [ADDR_W-1:0] grant_addr;

    logic              emit;
    status_t           emit_status;
    logic [ADDR_W-1:0] emit_granted;
    logic [HEAD_W-1:0] emit_count;

    tpfla_ram #(.WIDTH(HEAD_W), .DEPTH(MAX_AREA_PAGES)) u_top_links (
        .aclk    (aclk),
        .wr_en   (ram_we[POOL_TOP]),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (sel_head[IDX_W-1:0]),
        .rd_data (top_link)
    );

    tpfla_ram #(.WIDTH(HEAD_W), .DEPTH(MAX_AREA_PAGES)) u_mid_links (
        .aclk    (aclk),
        .wr_en   (ram_we[POOL_MID]),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (sel_head[IDX_W-1:0]),
        .rd_data (mid_link)
    );

    tpfla_ram #(.WIDTH(HEAD_W), .DEPTH(MAX_AREA_PAGES)) u_leaf_links (
        .aclk    (aclk),
        .wr_en   (ram_we[POOL_LEAF]),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (sel_head[IDX_W-1:0]),
        .rd_data (leaf_link)
    );

    always_comb begin
        case (cmd.pool)
            POOL_TOP: begin
                sel_head = top_head_reg;
                sel_link = top_link;
                sel_off  = '0;
            end
            POOL_MID: begin
                sel_head = mid_head_reg;
                sel_link = mid_link;
                sel_off  = geo.mid_off;
            end
            default: begin
                sel_head = leaf_head_reg;
                sel_link = leaf_link;
                sel_off  = geo.leaf_off;
            end
        endcase
    end

    assign cmd_idx    = cmd.idx[IDX_W-1:0];
    assign out_free   = !out_valid_reg || out_ready;
    assign cnt_inc    = (free_cnt_reg < EMPTY_MARK) ? free_cnt_reg + HEAD_W'(1) : free_cnt_reg;
    assign cnt_dec    = (free_cnt_reg != '0) ? free_cnt_reg - HEAD_W'(1) : free_cnt_reg;
    assign geo_total  = geo.leaf_off + geo.leaf_size;
    assign sweep_last = (GEO_W'(sweep_reg) + GEO_W'(1)) >= geo.max_size;
    assign grant_addr = area_base + ((ADDR_W'(sel_off) + ADDR_W'(sel_head)) << PAGE_SHIFT);

    always_comb begin
        state_next     = state_reg;
        top_head_next  = top_head_reg;
        mid_head_next  = mid_head_reg;
        leaf_head_next = leaf_head_reg;
        free_cnt_next  = free_cnt_reg;
        sweep_next     = sweep_reg;
        cmd_ready      = 1'b0;
        ram_we         = '0;
        ram_waddr      = cmd_idx;
        ram_wdata      = sel_head;
        ram_re         = 1'b0;
        emit           = 1'b0;
        emit_status    = ST_OK;
        emit_granted   = '0;
        emit_count     = free_cnt_reg;

        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        CMD_INIT: begin
                            sweep_next = '0;
                            state_next = BK_INIT_SWEEP;
                        end
                        CMD_ALLOC: begin
                            if (sel_head == EMPTY_MARK) begin
                                if (out_free) begin
                                    emit        = 1'b1;
                                    emit_status = ST_EMPTY;
                                    cmd_ready   = 1'b1;
                                end
                            end else begin
                                // fetch the successor of the head
                                ram_re     = 1'b1;
                                state_next = BK_ALLOC_RD;
                            end
                        end
                        CMD_FREE: begin
                            if (out_free) begin
                                // push: link the page to the old head, make it the head
                                case (cmd.pool)
                                    POOL_TOP: begin
                                        ram_we[POOL_TOP] = 1'b1;
                                        top_head_next    = HEAD_W'(cmd_idx);
                                    end
                                    POOL_MID: begin
                                        ram_we[POOL_MID] = 1'b1;
                                        mid_head_next    = HEAD_W'(cmd_idx);
                                    end
                                    default: begin
                                        ram_we[POOL_LEAF] = 1'b1;
                                        leaf_head_next    = HEAD_W'(cmd_idx);
                                    end
                                endcase
                                free_cnt_next = cnt_inc;
                                emit          = 1'b1;
                                emit_count    = cnt_inc;
                                cmd_ready     = 1'b1;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                emit        = 1'b1;
                                emit_status = cmd.status;
                                cmd_ready   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BK_ALLOC_RD: begin
                if (out_free) begin
                    case (cmd.pool)
                        POOL_TOP: top_head_next = sel_link;
                        POOL_MID: mid_head_next = sel_link;
                        default:  leaf_head_next = sel_link;
                    endcase
                    free_cnt_next = cnt_dec;
                    emit          = 1'b1;
                    emit_granted  = grant_addr;
                    emit_count    = cnt_dec;
                    cmd_ready     = 1'b1;
                    state_next    = BK_IDLE;
                end
            end
            BK_INIT_SWEEP: begin
                // entry i links to i-1; entry 0 ends the list
                ram_waddr = sweep_reg;
                ram_wdata = (sweep_reg == '0) ? EMPTY_MARK : HEAD_W'(sweep_reg) - HEAD_W'(1);
                ram_we[POOL_TOP]  = GEO_W'(sweep_reg) < geo.top_size;
                ram_we[POOL_MID]  = GEO_W'(sweep_reg) < geo.mid_size;
                ram_we[POOL_LEAF] = GEO_W'(sweep_reg) < geo.leaf_size;
                if (sweep_last) begin
                    state_next = BK_INIT_DONE;
                end else begin
                    sweep_next = sweep_reg + IDX_W'(1);
                end
            end
            BK_INIT_DONE: begin
                if (out_free) begin
                    top_head_next  = (geo.top_size == '0) ? EMPTY_MARK :
                                     HEAD_W'(geo.top_size - GEO_W'(1));
                    mid_head_next  = (geo.mid_size == '0) ? EMPTY_MARK :
                                     HEAD_W'(geo.mid_size - GEO_W'(1));
                    leaf_head_next = (geo.leaf_size == '0) ? EMPTY_MARK :
                                     HEAD_W'(geo.leaf_size - GEO_W'(1));
                    free_cnt_next  = HEAD_W'(geo_total);
                    emit           = 1'b1;
                    emit_count     = HEAD_W'(geo_total);
                    cmd_ready      = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_free_next    = out_free_reg;
        if (emit) begin
            out_valid_next   = 1'b1;
            out_status_next  = emit_status;
            out_granted_next = emit_granted;
            out_free_next    = FREE_W'(emit_count);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            top_head_reg  <= EMPTY_MARK;
            mid_head_reg  <= EMPTY_MARK;
            leaf_head_reg <= EMPTY_MARK;
            free_cnt_reg  <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            top_head_reg  <= top_head_next;
            mid_head_reg  <= mid_head_next;
            leaf_head_reg <= leaf_head_next;
            free_cnt_reg  <= free_cnt_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
        out_free_reg    <= out_free_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_granted    = out_granted_reg;
    assign out_free_pages = out_free_reg;

endmodule

// ----- rtl/core/three_pool_page_free_list_allocator_unit.sv -----
// Path: front register and classify, command queue, back end, result register; alloc adds a head
//   read of the link memory before the head update, init one link-memory write per page index.
// Throughput: one free or check per cycle while the result stream is not stalled; the back end
//   takes no new command until an alloc or init (sweep up to the max pool size) has completed.
// Reset (aresetn low, synchronous): registers to 0/12/0/2, all pools empty, counter zero;
//   link memories keep their contents, so every pool needs an init before use.
module three_pool_page_free_list_allocator_unit #(
    parameter int MAX_AREA_PAGES = tpfla_pkg::DEF_MAX_AREA_PAGES,
    parameter int PAGE_BYTES     = tpfla_pkg::DEF_PAGE_BYTES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [1:0] opcode, [3:2] pool, [67:4] page_address, rest zero
    input  logic [tpfla_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] status, [65:2] granted_address, [78:66] free_pages, rest zero
    output logic [tpfla_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // Register write port: 0 area_base, 1 area_order, 2 top_pool_order, 3 mid_pool_order
    input  logic                             cfg_wr_en,
    input  logic [tpfla_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [tpfla_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import tpfla_pkg::*;

    // Configuration registers
    logic [ADDR_W-1:0]  area_base_reg;
    logic [ORDER_W-1:0] area_order_reg;
    logic [ORDER_W-1:0] top_order_reg;
    logic [ORDER_W-1:0] mid_order_reg;
    // Pool sizes and offsets, recomputed every cycle from the registers.
    // Registers must only change while idle, a rule for the user that the block does not enforce;
    // kept, the lag of geo_reg is never seen by the classify stage, which works on the registered item.
    geo_t               geo_reg;

    logic [OPC_W-1:0]   in_opcode;
    logic [POOL_W-1:0]  in_pool;
    logic [ADDR_W-1:0]  in_page_address;

    logic               push_valid;
    logic               push_ready;
    cmd_t               push_cmd;
    logic               pop_valid;
    logic               pop_ready;
    logic [$bits(cmd_t)-1:0] pop_data;

    logic [STATUS_W-1:0] out_status;
    logic [ADDR_W-1:0]   out_granted;
    logic [FREE_W-1:0]   out_free_pages;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_base_reg  <= RST_AREA_BASE;
            area_order_reg <= RST_AREA_ORDER;
            top_order_reg  <= RST_TOP_ORDER;
            mid_order_reg  <= RST_MID_ORDER;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_AREA_BASE:  area_base_reg  <= cfg_wr_data;
                REG_AREA_ORDER: area_order_reg <= cfg_wr_data[ORDER_W-1:0];
                REG_TOP_ORDER:  top_order_reg  <= cfg_wr_data[ORDER_W-1:0];
                REG_MID_ORDER:  mid_order_reg  <= cfg_wr_data[ORDER_W-1:0];
                default:        area_base_reg  <= area_base_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        geo_reg <= pool_geometry(area_order_reg, top_order_reg, mid_order_reg,
                                 GEO_W'(MAX_AREA_PAGES));
    end

    // Unpack the request transfer
    assign in_opcode       = s_axis_tdata[OPC_W-1:0];
    assign in_pool         = s_axis_tdata[OPC_W +: POOL_W];
    assign in_page_address = s_axis_tdata[OPC_W + POOL_W +: ADDR_W];

    // Front: register the item, then classify (alignment, pool range) into a command
    tpfla_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_opcode       (in_opcode),
        .in_pool         (in_pool),
        .in_page_address (in_page_address),
        .area_base       (area_base_reg),
        .geo             (geo_reg),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_cmd        (push_cmd)
    );

    // Decouple classification from execution so an alloc read does not stall intake
    tpfla_queue #(.WIDTH($bits(cmd_t)), .DEPTH(CMDQ_DEPTH)) u_cmd_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: heads, link memories, free counter and the result register
    tpfla_back #(
        .MAX_AREA_PAGES (MAX_AREA_PAGES),
        .PAGE_BYTES     (PAGE_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (pop_valid),
        .cmd_ready      (pop_ready),
        .cmd            (cmd_t'(pop_data)),
        .area_base      (area_base_reg),
        .geo            (geo_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_status     (out_status),
        .out_granted    (out_granted),
        .out_free_pages (out_free_pages)
    );

    // Pack the result transfer
    assign m_axis_tdata = {{M_PAD_W{1'b0}}, out_free_pages, out_granted, out_status};

endmodule

// ----- rtl/core/tpfla_checker.sv -----
// Port-level checker for the three-pool page allocator, bound to the top level.
// Depends on tpfla_pkg and the assertion macro header.
`include "three_pool_page_free_list_allocator_unit_assert.svh"

module tpfla_checker #(
    parameter int MAX_AREA_PAGES = tpfla_pkg::DEF_MAX_AREA_PAGES
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tpfla_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import tpfla_pkg::*;

    logic [STATUS_W-1:0] res_status;
    logic [ADDR_W-1:0]   res_granted;
    logic [FREE_W-1:0]   res_free;

    assign res_status  = m_axis_tdata[STATUS_W-1:0];
    assign res_granted = m_axis_tdata[STATUS_W +: ADDR_W];
    assign res_free    = m_axis_tdata[STATUS_W + ADDR_W +: FREE_W];

    `TPFLA_ASSERT_NEXT_ALWAYS(a_reset_clears_result, aclk, !aresetn, !m_axis_tvalid, "result valid right after reset")
    `TPFLA_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `TPFLA_ASSERT_SAME(a_grant_only_on_ok, aclk, aresetn, m_axis_tvalid && (res_status != ST_OK), res_granted == '0, "address granted with error status")
    `TPFLA_ASSERT_SAME(a_free_count_bound, aclk, aresetn, m_axis_tvalid, 32'(res_free) <= 32'(MAX_AREA_PAGES), "free count above area capacity")

endmodule

bind three_pool_page_free_list_allocator_unit tpfla_checker #(
    .MAX_AREA_PAGES (MAX_AREA_PAGES)
) u_tpfla_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
